[sv/tdjs_pkg.sv]
// ----------------------------------------------------------------------------
// tdjs_pkg
// shared types and constants of the tick driven job scheduler
// ----------------------------------------------------------------------------
package tdjs_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IW       = (MAX_JOBS > 2) ? $clog2(MAX_JOBS) : 1;
    localparam int CW       = $clog2(MAX_JOBS + 1);
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] CFG_POLICY  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_QUANTUM = CFG_IW'(1);

    localparam logic [1:0] MODE_RR   = 2'd0;
    localparam logic [1:0] MODE_SRTF = 2'd1;

    localparam logic [2:0] SW_NONE     = 3'd0;
    localparam logic [2:0] SW_DISPATCH = 3'd1;
    localparam logic [2:0] SW_COMPLETE = 3'd2;
    localparam logic [2:0] SW_ROTATE   = 3'd3;
    localparam logic [2:0] SW_PREEMPT  = 3'd4;

    localparam logic [15:0] QUANTUM_RESET = 16'd3;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  job_id;
        logic [15:0] burst_length;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        running_valid;
        logic [7:0]  running_id;
        logic [2:0]  switch_kind;
        logic        done_valid;
        logic [7:0]  done_id;
        logic [31:0] done_turnaround;
        logic [31:0] done_waiting;
        logic [31:0] tick_number;
    } t_res;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rem;
        logic [31:0] wait_cnt;
        logic [31:0] arr;
    } t_slot;

    typedef struct packed {
        logic          found;
        logic [15:0]   rem;
        logic [IW-1:0] idx;
    } t_cand;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_WRITE,
        COP_SHIFT,
        COP_UPDATE,
        COP_SEARCH
    } t_cop;

    typedef struct packed {
        t_cop          op;
        logic [IW-1:0] idx;
        logic [CW-1:0] count;
        logic          rot;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RET,
        S_SRCH,
        S_DEC,
        S_UPD,
        S_FIN
    } t_state;

endpackage

[sv/tdjs_cell.sv]
// ----------------------------------------------------------------------------
// tdjs_cell
// one table slot with shift link to its right neighbor and a min search stage
// ----------------------------------------------------------------------------
module tdjs_cell (
    input  logic                    i_clk,
    input  logic [tdjs_pkg::IW-1:0] i_my_idx,
    input  tdjs_pkg::t_cell_ctl     i_ctl,
    input  tdjs_pkg::t_slot         i_load,
    input  tdjs_pkg::t_slot         i_right,
    input  tdjs_pkg::t_cand         i_cand,
    output tdjs_pkg::t_slot         o_slot,
    output tdjs_pkg::t_cand         o_cand
);
    import tdjs_pkg::*;

    t_slot r_slot, n_slot;
    t_cand r_cand, n_cand;
    logic  w_live;

    assign w_live = CW'(i_my_idx) < i_ctl.count;

    always_comb begin
        n_slot = r_slot;
        n_cand = r_cand;
        case (i_ctl.op)
            COP_WRITE: begin
                if (i_my_idx == i_ctl.idx) begin
                    n_slot = i_load;
                end
            end
            COP_SHIFT: begin
                if (i_my_idx >= i_ctl.idx && (CW'(i_my_idx) + CW'(1)) < i_ctl.count) begin
                    n_slot = i_right;
                end else if (i_ctl.rot && (CW'(i_my_idx) + CW'(1)) == i_ctl.count) begin
                    n_slot = i_load;
                end
            end
            COP_UPDATE: begin
                if (w_live && i_my_idx != i_ctl.idx) begin
                    n_slot.wait_cnt = r_slot.wait_cnt + 32'd1;
                end
                if (i_my_idx == i_ctl.idx && r_slot.rem != 16'd0) begin
                    n_slot.rem = r_slot.rem - 16'd1;
                end
            end
            COP_SEARCH: begin
                if (w_live && (!i_cand.found || r_slot.rem < i_cand.rem)) begin
                    n_cand = '{found: 1'b1, rem: r_slot.rem, idx: i_my_idx};
                end else begin
                    n_cand = i_cand;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_cand <= n_cand;
    end

    assign o_slot = r_slot;
    assign o_cand = r_cand;

endmodule

[sv/tick_driven_job_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tick_driven_job_scheduler_unit
// ready table of jobs in a row of slot cells, served round robin, srtf or sjf
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | in        | i_in_valid/o_in_ready  | i_in_item (t_req)
// out     | out       | o_out_valid/i_out_ready| o_out_item (t_res)
// cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// an arrival item is handled directly in the idle state; a tick item runs retire, decide,
// update and result, with a minimum search through the cell row before decide when one runs
// a tick that leaves the table empty runs only retire and result
// a stalled output holds the result step; the next item is taken once the unit is idle again
// synchronous active-low reset empties the table and restores the control registers
// input is taken only when idle and the output register is free or being taken
module tick_driven_job_scheduler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tdjs_pkg::t_req              i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tdjs_pkg::t_res              o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tdjs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);
    import tdjs_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_run_slot, n_run_slot;
    logic          r_run_flag, n_run_flag;
    logic [15:0]   r_slice, n_slice;
    logic [31:0]   r_tick, n_tick;
    logic [1:0]    r_mode, n_mode;
    logic [15:0]   r_quantum, n_quantum;
    logic          r_completed, n_completed;
    logic [IW-1:0] r_comp_idx, n_comp_idx;
    logic [IW-1:0] r_chosen, n_chosen;
    logic [2:0]    r_kind, n_kind;
    logic [CW-1:0] r_srch_cnt, n_srch_cnt;
    logic          r_done_valid, n_done_valid;
    logic [7:0]    r_done_id, n_done_id;
    logic [31:0]   r_done_turn, n_done_turn;
    logic [31:0]   r_done_wait, n_done_wait;
    logic          r_run_valid, n_run_valid;
    logic [7:0]    r_run_id, n_run_id;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;

    t_cell_ctl     w_ctl;
    t_slot         w_load;
    t_slot         w_slot  [MAX_JOBS];
    t_cand         w_cand  [MAX_JOBS];
    t_slot         w_right [MAX_JOBS];
    t_cand         w_cin   [MAX_JOBS];
    t_slot         w_sel;
    logic [IW-1:0] w_sel_idx;
    logic          w_in_acc;
    logic          w_run_ok;
    logic          w_retire;
    logic          w_flag_after;
    logic [CW-1:0] w_count_after;
    logic [15:0]   w_q;
    logic [IW-1:0] w_min;

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++) begin : g_cell
            if (g == MAX_JOBS - 1) begin : g_last
                assign w_right[g] = '0;
            end else begin : g_mid
                assign w_right[g] = w_slot[g+1];
            end
            if (g == 0) begin : g_first
                assign w_cin[g] = '0;
            end else begin : g_next
                assign w_cin[g] = w_cand[g-1];
            end
            tdjs_cell u_cell (
                .i_clk    (i_clk),
                .i_my_idx (IW'(g)),
                .i_ctl    (w_ctl),
                .i_load   (w_load),
                .i_right  (w_right[g]),
                .i_cand   (w_cin[g]),
                .o_slot   (w_slot[g]),
                .o_cand   (w_cand[g])
            );
        end
    endgenerate

    assign w_sel_idx     = (r_state == S_UPD) ? r_chosen : r_run_slot;
    assign w_sel         = w_slot[w_sel_idx];
    assign w_min         = w_cand[MAX_JOBS-1].idx;
    assign w_in_acc      = i_in_valid && o_in_ready;
    assign w_run_ok      = r_run_flag && (CW'(r_run_slot) < r_count);
    assign w_retire      = w_run_ok && (w_sel.rem == 16'd0);
    assign w_flag_after  = w_run_ok && !w_retire;
    assign w_count_after = w_retire ? (r_count - CW'(1)) : r_count;
    assign w_q           = (r_quantum == 16'd0) ? 16'd1 : r_quantum;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_run_slot   = r_run_slot;
        n_run_flag   = r_run_flag;
        n_slice      = r_slice;
        n_tick       = r_tick;
        n_mode       = r_mode;
        n_quantum    = r_quantum;
        n_completed  = r_completed;
        n_comp_idx   = r_comp_idx;
        n_chosen     = r_chosen;
        n_kind       = r_kind;
        n_srch_cnt   = r_srch_cnt;
        n_done_valid = r_done_valid;
        n_done_id    = r_done_id;
        n_done_turn  = r_done_turn;
        n_done_wait  = r_done_wait;
        n_run_valid  = r_run_valid;
        n_run_id     = r_run_id;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        w_ctl        = '{op: COP_HOLD, idx: '0, count: r_count, rot: 1'b0};
        w_load       = w_sel;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLICY:  n_mode = i_cfg_data[1:0];
                CFG_QUANTUM: n_quantum = i_cfg_data;
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_item.req_type) begin
                        n_completed = 1'b0;
                        n_state     = S_RET;
                    end else begin
                        n_out             = '0;
                        n_out.tick_number = r_tick;
                        n_out_valid       = 1'b1;
                        if (i_in_item.burst_length != 16'd0 && r_count < CW'(MAX_JOBS)) begin
                            w_ctl.op         = COP_WRITE;
                            w_ctl.idx        = r_count[IW-1:0];
                            w_load.id        = i_in_item.job_id;
                            w_load.rem       = i_in_item.burst_length;
                            w_load.wait_cnt  = 32'd0;
                            w_load.arr       = r_tick;
                            n_count          = r_count + CW'(1);
                            n_out.accepted   = 1'b1;
                        end
                    end
                end
            end
            S_RET: begin
                n_done_valid = w_retire;
                n_done_id    = w_retire ? w_sel.id : 8'd0;
                n_done_turn  = w_retire ? (r_tick - w_sel.arr) : 32'd0;
                n_done_wait  = w_retire ? w_sel.wait_cnt : 32'd0;
                n_run_flag   = w_flag_after;
                n_count      = w_count_after;
                n_completed  = w_retire;
                n_comp_idx   = r_run_slot;
                n_srch_cnt   = '0;
                if (w_retire) begin
                    w_ctl.op  = COP_SHIFT;
                    w_ctl.idx = r_run_slot;
                end
                if (w_count_after == '0) begin
                    n_run_valid = 1'b0;
                    n_run_id    = 8'd0;
                    n_kind      = SW_NONE;
                    n_state     = S_FIN;
                end else if (r_mode != MODE_RR && (!w_flag_after || r_mode == MODE_SRTF)) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_SRCH: begin
                w_ctl.op   = COP_SEARCH;
                n_srch_cnt = r_srch_cnt + CW'(1);
                if (r_srch_cnt == CW'(MAX_JOBS - 1)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_UPD;
                if (!r_run_flag) begin
                    if (r_mode == MODE_RR) begin
                        n_chosen = (r_completed && CW'(r_comp_idx) < r_count) ? r_comp_idx : '0;
                    end else begin
                        n_chosen = w_min;
                    end
                    n_kind  = r_completed ? SW_COMPLETE : SW_DISPATCH;
                    n_slice = 16'd0;
                end else begin
                    n_chosen = r_run_slot;
                    n_kind   = SW_NONE;
                    if (r_mode == MODE_RR) begin
                        if (r_slice >= w_q) begin
                            if ((CW'(r_run_slot) + CW'(1)) < r_count) begin
                                w_ctl.op  = COP_SHIFT;
                                w_ctl.idx = r_run_slot;
                                w_ctl.rot = 1'b1;
                                n_chosen  = '0;
                                n_kind    = SW_ROTATE;
                            end
                            n_slice = 16'd0;
                        end
                    end else if (r_mode == MODE_SRTF) begin
                        if (w_min != r_run_slot) begin
                            n_chosen = w_min;
                            n_kind   = SW_PREEMPT;
                            n_slice  = 16'd0;
                        end
                    end
                end
            end
            S_UPD: begin
                w_ctl.op    = COP_UPDATE;
                w_ctl.idx   = r_chosen;
                n_run_slot  = r_chosen;
                n_run_flag  = 1'b1;
                n_slice     = (r_slice == 16'hFFFF) ? r_slice : (r_slice + 16'd1);
                n_run_valid = 1'b1;
                n_run_id    = w_sel.id;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.accepted        = 1'b0;
                    n_out.running_valid   = r_run_valid;
                    n_out.running_id      = r_run_id;
                    n_out.switch_kind     = r_kind;
                    n_out.done_valid      = r_done_valid;
                    n_out.done_id         = r_done_id;
                    n_out.done_turnaround = r_done_turn;
                    n_out.done_waiting    = r_done_wait;
                    n_out.tick_number     = r_tick;
                    n_out_valid           = 1'b1;
                    n_tick                = r_tick + 32'd1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_run_slot  <= '0;
            r_run_flag  <= 1'b0;
            r_slice     <= 16'd0;
            r_tick      <= 32'd0;
            r_mode      <= MODE_RR;
            r_quantum   <= QUANTUM_RESET;
            r_completed <= 1'b0;
            r_srch_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_run_slot  <= n_run_slot;
            r_run_flag  <= n_run_flag;
            r_slice     <= n_slice;
            r_tick      <= n_tick;
            r_mode      <= n_mode;
            r_quantum   <= n_quantum;
            r_completed <= n_completed;
            r_srch_cnt  <= n_srch_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_comp_idx   <= n_comp_idx;
        r_chosen     <= n_chosen;
        r_kind       <= n_kind;
        r_done_valid <= n_done_valid;
        r_done_id    <= n_done_id;
        r_done_turn  <= n_done_turn;
        r_done_wait  <= n_done_wait;
        r_run_valid  <= n_run_valid;
        r_run_id     <= n_run_id;
        r_out        <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_JOBS))
        else $error("table count above capacity");

    a_run_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run_flag) |-> (CW'(r_run_slot) < r_count))
        else $error("running slot outside table");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input taken while busy");

    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || i_out_ready)) |=> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick count not advanced");

endmodule
